// ===== src/rlfa_pkg.sv =====
// Shared types and constants for the ring log flash address generator.
// No dependencies; the other files, apart from rlfa_div, refer to this package by scoped names.
package rlfa_pkg;

    localparam int LOG_DEPTH_DEF = 500;
    localparam int ADDR_BITS_DEF = 24;

    // Function codes of an input item
    localparam logic [2:0] FUNC_SAVE_REC = 3'd0;
    localparam logic [2:0] FUNC_LOAD_REC = 3'd1;
    localparam logic [2:0] FUNC_SAVE_ALM = 3'd2;
    localparam logic [2:0] FUNC_LOAD_ALM = 3'd3;
    localparam logic [2:0] FUNC_CLEAR    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_BINARY_PAGE = 2'd0;
    localparam logic [1:0] CFG_PAGE_SIZE   = 2'd1;
    localparam logic [1:0] CFG_PAGE_SHIFT  = 2'd2;

    // Log geometry
    localparam logic [6:0]  REC_LEN      = 7'd74;
    localparam logic [11:0] REC_PER_PAGE = 12'd3;
    localparam logic [7:0]  REC_BASE     = 8'd0;
    localparam logic [6:0]  ALM_LEN      = 7'd8;
    localparam logic [11:0] ALM_PER_PAGE = 12'd2;
    localparam logic [7:0]  ALM_BASE     = 8'd222;

    // Reset values of the configuration registers
    localparam logic        BINARY_PAGE_RST = 1'b0;
    localparam logic [11:0] PAGE_SIZE_RST   = 12'd264;
    localparam logic [3:0]  PAGE_SHIFT_RST  = 4'd9;

    typedef struct packed {
        logic [2:0] func;
        logic [8:0] back_index;
    } t_in;

    typedef struct packed {
        logic [23:0] flash_address;
        logic        write_access;
        logic        access_valid;
        logic [6:0]  byte_count;
        logic [8:0]  record_count;
        logic [8:0]  alarm_count;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic load;      // capture the input item
        logic prep;      // resolve slot, update log counters
        logic split;     // register page index and entry within the page
        logic lin;       // register the linear address
        logic div_page;  // start linear / page size
        logic form;      // register the device address
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_addr; // current item reaches a flash entry
        logic bypass;    // device address equals linear address
        logic div_idle;
    } t_sts;

endpackage

// ===== src/ring_log_flash_address_gen.sv =====
// Top level of the ring log flash address generator: controller plus datapath.
// Depends on rlfa_pkg, rlfa_ctrl, rlfa_dp (and rlfa_div below it).
//
// An item is taken when start is high and busy is low; busy stays high until
// its single result has been shown on o_result for one cycle with
// o_result_valid high. The receiver cannot stall, so sample the result in that
// cycle. An item that reaches flash goes through the prep, split, linear-address
// and page states and, in 264-style mode with a nonzero page size, through the
// serial page divider, which delivers one quotient bit per cycle; a clear, an
// unused code or a rejected load goes from prep straight to the output state.
// Configuration writes are always ready and must only be issued while idle.
module ring_log_flash_address_gen #(
    parameter int LOG_DEPTH = rlfa_pkg::LOG_DEPTH_DEF,
    parameter int ADDR_BITS = rlfa_pkg::ADDR_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  rlfa_pkg::t_in  i_item,
    output logic           busy,
    output logic           o_result_valid,
    output rlfa_pkg::t_out o_result,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [11:0]    i_cfg_data
);

    rlfa_pkg::t_cmd cmd;
    rlfa_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    rlfa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_sts          (sts),
        .o_cmd          (cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    rlfa_dp #(
        .LOG_DEPTH (LOG_DEPTH),
        .ADDR_BITS (ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result)
    );

endmodule

// ===== src/rlfa_div.sv =====
// Restoring serial divider, one quotient bit per clock, 12-bit divisor.
// Depends on nothing but its parameters.
module rlfa_div #(
    parameter int NUM_W = 18,
    parameter int CNT_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [11:0]      i_den,
    input  logic [CNT_W-1:0] i_steps,
    output logic             o_idle,
    output logic [NUM_W-1:0] o_quo,
    output logic [11:0]      o_rem
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [11:0]      r_rem, n_rem;
    logic [11:0]      r_den;
    logic [12:0]      trial;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        ge    = trial >= {1'b0, r_den};
        n_cnt = r_cnt;
        n_quo = r_quo;
        n_rem = r_rem;
        if (i_start) begin
            n_cnt = i_steps;
            n_quo = i_num;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_quo = {r_quo[NUM_W-2:0], ge};
            n_rem = ge ? 12'(trial - {1'b0, r_den}) : trial[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_idle = (r_cnt == '0);
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

// ===== src/rlfa_dp.sv =====
// Datapath: log counters, configuration registers, slot resolution,
// linear and device address forming. Uses rlfa_pkg and rlfa_div.
module rlfa_dp #(
    parameter int LOG_DEPTH = rlfa_pkg::LOG_DEPTH_DEF,
    parameter int ADDR_BITS = rlfa_pkg::ADDR_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rlfa_pkg::t_in  i_item,
    input  rlfa_pkg::t_cmd i_cmd,
    output rlfa_pkg::t_sts o_sts,
    input  logic           i_cfg_wr,
    input  logic [1:0]     i_cfg_index,
    input  logic [11:0]    i_cfg_data,
    output rlfa_pkg::t_out o_result
);

    localparam int SW     = $clog2(LOG_DEPTH + 1);
    localparam int XW     = ((SW > 9) ? SW : 9) + 1;
    localparam int LIN_W  = SW + 9;
    localparam int DEV_W  = ((LIN_W + 16) > 32) ? (LIN_W + 16) : 32;
    localparam int CNT_W  = $clog2(LIN_W + 1);
    localparam logic [31:0] AMASK = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                    32'((64'd1 << ADDR_BITS) - 64'd1);
    // floor(x / 3) = (x * 43691) >> 17 for every x below 2**17
    localparam logic [16:0] THIRD_RECIP = 17'd43691;

    // configuration
    logic        r_binary_page;
    logic [11:0] r_page_size;
    logic [3:0]  r_page_shift;

    // log state
    logic [SW-1:0] r_next_rec, r_next_alm;
    logic          r_wrap_rec, r_wrap_alm;

    // item
    logic [2:0]  r_func;
    logic [8:0]  r_back;
    logic        r_valid;
    logic [SW-1:0] r_slot, r_pq;
    logic [1:0]  r_pr;
    logic [LIN_W-1:0] r_lin;
    logic [23:0] r_flash;

    // divider
    logic             div_idle;
    logic [LIN_W-1:0] div_quo;
    logic [11:0]      div_rem;

    logic          is_rec, is_save, is_load;
    logic [SW-1:0] cur_next, sv_slot, slot_c;
    logic          ld_ok, valid_c, wrap_now;
    logic [XW-1:0] nx, bk, nx_up;

    always_comb begin
        is_rec   = (r_func == rlfa_pkg::FUNC_SAVE_REC) || (r_func == rlfa_pkg::FUNC_LOAD_REC);
        is_save  = (r_func == rlfa_pkg::FUNC_SAVE_REC) || (r_func == rlfa_pkg::FUNC_SAVE_ALM);
        is_load  = (r_func == rlfa_pkg::FUNC_LOAD_REC) || (r_func == rlfa_pkg::FUNC_LOAD_ALM);
        cur_next = is_rec ? r_next_rec : r_next_alm;
        wrap_now = (XW'(cur_next) >= XW'(LOG_DEPTH));
        sv_slot  = wrap_now ? '0 : cur_next;
        nx       = XW'(cur_next);
        bk       = XW'(r_back);
        nx_up    = nx + XW'(LOG_DEPTH);
        ld_ok    = 1'b0;
        slot_c   = sv_slot;
        if (is_load) begin
            if (nx == '0) begin
                ld_ok = 1'b0;
            end else if (bk <= nx) begin
                ld_ok  = 1'b1;
                slot_c = SW'(nx - bk);
            end else if (bk <= nx_up) begin
                ld_ok  = 1'b1;
                slot_c = SW'(nx_up - bk);
            end
        end
        valid_c = is_save || (is_load && ld_ok);
    end

    assign o_sts.need_addr = valid_c;
    assign o_sts.bypass    = r_binary_page || (r_page_size == '0);
    assign o_sts.div_idle  = div_idle;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binary_page <= rlfa_pkg::BINARY_PAGE_RST;
            r_page_size   <= rlfa_pkg::PAGE_SIZE_RST;
            r_page_shift  <= rlfa_pkg::PAGE_SHIFT_RST;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                rlfa_pkg::CFG_BINARY_PAGE: r_binary_page <= i_cfg_data[0];
                rlfa_pkg::CFG_PAGE_SIZE:   r_page_size   <= i_cfg_data;
                rlfa_pkg::CFG_PAGE_SHIFT:  r_page_shift  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // log counters advance on a save, drop to zero on clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_rec <= '0;
            r_wrap_rec <= 1'b0;
            r_next_alm <= '0;
            r_wrap_alm <= 1'b0;
            r_valid    <= 1'b0;
        end else if (i_cmd.prep) begin
            r_valid <= valid_c;
            unique case (r_func)
                rlfa_pkg::FUNC_SAVE_REC: begin
                    r_next_rec <= SW'({1'b0, sv_slot} + (SW + 1)'(1));
                    if (wrap_now) r_wrap_rec <= 1'b1;
                end
                rlfa_pkg::FUNC_SAVE_ALM: begin
                    r_next_alm <= SW'({1'b0, sv_slot} + (SW + 1)'(1));
                    if (wrap_now) r_wrap_alm <= 1'b1;
                end
                rlfa_pkg::FUNC_CLEAR: begin
                    r_next_rec <= '0;
                    r_wrap_rec <= 1'b0;
                    r_next_alm <= '0;
                    r_wrap_alm <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // page index and entry within the page: divide by 3 or by 2
    logic [SW+16:0] prod3;
    logic [SW-1:0]  q3;
    logic [1:0]     r3;

    always_comb begin
        prod3 = (SW + 17)'(r_slot) * (SW + 17)'(THIRD_RECIP);
        q3    = prod3[SW+16:17];
        r3    = 2'(r_slot - ((q3 << 1) + q3));
    end

    rlfa_div #(
        .NUM_W (LIN_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_page),
        .i_num   (r_lin),
        .i_den   (r_page_size),
        .i_steps (CNT_W'(LIN_W)),
        .o_idle  (div_idle),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    logic [LIN_W-1:0] q_ext, lin_c;
    logic [LIN_W-1:0] in_page;
    logic [DEV_W-1:0] dev_c;
    logic [31:0]      dev32;

    always_comb begin
        q_ext = LIN_W'(r_pq);
        if (is_rec) begin
            in_page = LIN_W'(rlfa_pkg::REC_BASE) +
                      LIN_W'(r_pr) * LIN_W'(rlfa_pkg::REC_LEN);
        end else begin
            in_page = LIN_W'(rlfa_pkg::ALM_BASE) +
                      LIN_W'(r_pr) * LIN_W'(rlfa_pkg::ALM_LEN);
        end
        // stride 256, or 264 = 256 + 8
        if (r_binary_page) begin
            lin_c = (q_ext << 8) + in_page;
        end else begin
            lin_c = (q_ext << 8) + (q_ext << 3) + in_page;
        end
        if (o_sts.bypass) begin
            dev_c = DEV_W'(r_lin);
        end else begin
            dev_c = (DEV_W'(div_quo) << r_page_shift) + DEV_W'(div_rem);
        end
        dev32 = dev_c[31:0] & AMASK;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_item.func;
            r_back <= i_item.back_index;
        end
        if (i_cmd.prep) begin
            r_slot <= slot_c;
        end
        if (i_cmd.split) begin
            if (is_rec) begin
                r_pq <= q3;
                r_pr <= r3;
            end else begin
                r_pq <= r_slot >> 1;
                r_pr <= {1'b0, r_slot[0]};
            end
        end
        if (i_cmd.lin) begin
            r_lin <= lin_c;
        end
        if (i_cmd.form) begin
            r_flash <= dev32[23:0];
        end
    end

    logic [XW-1:0] rec_cnt, alm_cnt;

    always_comb begin
        rec_cnt = r_wrap_rec ? XW'(LOG_DEPTH) : XW'(r_next_rec);
        alm_cnt = r_wrap_alm ? XW'(LOG_DEPTH) : XW'(r_next_alm);
        o_result.flash_address = r_valid ? r_flash : '0;
        o_result.write_access  = is_save;
        o_result.access_valid  = r_valid;
        if (!r_valid) begin
            o_result.byte_count = '0;
        end else begin
            o_result.byte_count = is_rec ? rlfa_pkg::REC_LEN : rlfa_pkg::ALM_LEN;
        end
        o_result.record_count = rec_cnt[8:0];
        o_result.alarm_count  = alm_cnt[8:0];
    end

endmodule

// ===== src/rlfa_ctrl.sv =====
// Controller state machine: sequences slot resolution, the slot split, the
// page divide and address forming. Uses rlfa_pkg command and status types.
module rlfa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rlfa_pkg::t_sts i_sts,
    output rlfa_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_result_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_SPLIT = 3'd2;
    localparam logic [2:0] S_LIN   = 3'd3;
    localparam logic [2:0] S_PG    = 3'd4;
    localparam logic [2:0] S_DIV2  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_sts.need_addr) begin
                    n_state = S_SPLIT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = S_LIN;
            end
            S_LIN: begin
                o_cmd.lin = 1'b1;
                n_state   = S_PG;
            end
            S_PG: begin
                // no page split needed: take the linear address as is
                if (i_sts.bypass) begin
                    o_cmd.form = 1'b1;
                    n_state    = S_OUT;
                end else begin
                    o_cmd.div_page = 1'b1;
                    n_state        = S_DIV2;
                end
            end
            S_DIV2: begin
                if (i_sts.div_idle) begin
                    o_cmd.form = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_OUT);

endmodule
